>>> hdl/urt_pkg.sv
// Shared types, codes and element compare for the unique row table.
package urt_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_MATCH   = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_READOUT = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  // Input command codes
  typedef enum logic {
    CMD_ELEMENT = 1'b0,
    CMD_FINISH  = 1'b1
  } command_t;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned RW_W    = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   index;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } result_t;

  // IEEE double equality: NaN matches nothing, +0 equals -0
  function automatic logic elem_equal(input logic [VALUE_W-1:0] a,
                                      input logic [VALUE_W-1:0] b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    a_nan     = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan     = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    return !a_nan && !b_nan && (both_zero || (a == b));
  endfunction

endpackage

>>> hdl/urt_elem_if.sv
// Input channel: one row element or a finish command per transaction.
interface urt_elem_if;
  import urt_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

>>> hdl/urt_result_if.sv
// Output channel: one table result per transaction.
interface urt_result_if;
  import urt_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [INDEX_W-1:0] index;
  logic [COUNT_W-1:0] count;
  logic               last;

  modport source (output valid, output status, output index, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input index, input count, input last,
                  output ready);
endinterface

>>> hdl/unique_row_table_with_counts_core.sv
// Unique row table with occurrence counts: sequencer, row and count memories.
// Sequence: an element that does not complete a row is taken in S_IDLE. A completed row
//   is compared element by element through S_CMP_WAIT and S_CMP_CHK (one row memory read
//   port), then S_HIT or S_FULL gives the result, or S_STORE writes the new row.
// Finish: S_RD_WAIT and S_RD_DATA per stored entry, S_EMPTY for an empty set. Not ready
//   while busy; a result that is not taken stalls the sequencer. Reset (rst, synchronous):
//   table empty, row width 1; no clearing pass, the fill count marks which entries hold data.
module unique_row_table_with_counts_core #(
  parameter int unsigned MAX_DISTINCT  = 64,
  parameter int unsigned MAX_ROW_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [urt_pkg::RW_W-1:0] cfg_data,
  urt_elem_if.sink              elem,
  urt_result_if.source          result
);
  import urt_pkg::*;

  localparam int unsigned KW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int unsigned EW = $clog2(MAX_DISTINCT);
  localparam int unsigned UW = $clog2(MAX_DISTINCT + 1);
  localparam int unsigned AW = $clog2(MAX_DISTINCT * MAX_ROW_WIDTH);
  localparam int unsigned RD = MAX_DISTINCT * MAX_ROW_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_CMP_WAIT, S_CMP_CHK, S_HIT, S_STORE, S_FULL, S_EMPTY, S_RD_WAIT, S_RD_DATA
  } state_t;

  state_t              state;
  logic [RW_W-1:0]     row_width;
  logic [UW-1:0]       entries_used;
  logic [KW-1:0]       pos;
  logic [KW-1:0]       k;
  logic [EW-1:0]       e;
  logic                res_valid;
  result_t             res;
  logic [VALUE_W-1:0]  row_buffer [MAX_ROW_WIDTH];

  // Memories
  logic [VALUE_W-1:0]  row_mem [RD];
  logic [COUNT_W-1:0]  cnt_mem [MAX_DISTINCT];
  logic [VALUE_W-1:0]  row_q;
  logic [COUNT_W-1:0]  cnt_q;

  logic [WW-1:0]       w_eff;
  logic [WW-1:0]       pos_inc;
  logic                k_last;
  logic                e_more;
  logic                out_free;
  logic                res_load;
  logic                elem_take;
  logic                is_full;
  logic [EW-1:0]       new_idx;
  logic [EW-1:0]       entry_sel;
  logic [AW-1:0]       row_addr;
  logic                row_we;
  logic                cnt_we;
  logic [EW-1:0]       cnt_waddr;
  logic [COUNT_W-1:0]  cnt_wdata;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                rd_last;

  // Clamp the row width into its legal range
  always_comb begin
    priority if (row_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(row_width) > MAX_ROW_WIDTH) begin
      w_eff = WW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = WW'(row_width);
    end
  end

  assign pos_inc   = WW'(pos) + WW'(1);
  assign k_last    = (WW'(k) + WW'(1)) == w_eff;
  assign e_more    = (UW'(e) + UW'(1)) < entries_used;
  assign rd_last   = !e_more;
  assign is_full   = entries_used == UW'(MAX_DISTINCT);
  assign new_idx   = entries_used[EW-1:0];
  assign out_free  = !res_valid || result.ready;
  assign elem_take = elem.valid && elem.ready;
  assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);

  // Load a result whenever the sequencer emits one into a free output register
  assign res_load  = out_free && ((state == S_HIT) || (state == S_FULL) ||
                                  (state == S_EMPTY) || (state == S_RD_DATA) ||
                                  (state == S_STORE && k_last));

  // Share one address path between compare reads and row stores
  assign entry_sel = (state == S_STORE) ? new_idx : e;
  assign row_addr  = AW'(32'(entry_sel) * MAX_ROW_WIDTH + 32'(k));
  assign row_we    = (state == S_STORE);

  // Count memory writes: increment on a hit, one on a new entry
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = e;
    cnt_wdata = cnt_inc;
    if (state == S_HIT && out_free) begin
      cnt_we = 1'b1;
    end else if (state == S_STORE && k_last && out_free) begin
      cnt_we    = 1'b1;
      cnt_waddr = new_idx;
      cnt_wdata = COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_addr] <= row_buffer[k];
    end
    row_q <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[e];
  end

  // Gather the row being built
  always_ff @(posedge clk) begin
    if (elem_take && elem.command == CMD_ELEMENT) begin
      row_buffer[pos] <= elem.value;
    end
  end

  assign elem.ready = (state == S_IDLE);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_width    <= RW_W'(1);
      entries_used <= '0;
      pos          <= '0;
      k            <= '0;
      e            <= '0;
      res_valid    <= 1'b0;
    end else begin
      // load a fresh result, or drop the held one once taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_write) begin
        row_width    <= cfg_data;
        entries_used <= '0;
        pos          <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (elem_take) begin
              k <= '0;
              e <= '0;
              if (elem.command == CMD_FINISH) begin
                state <= (entries_used == '0) ? S_EMPTY : S_RD_WAIT;
              end else if (pos_inc == w_eff) begin
                pos   <= '0;
                state <= (entries_used == '0) ? S_STORE : S_CMP_WAIT;
              end else begin
                pos <= KW'(pos_inc);
              end
            end
          end
          S_CMP_WAIT: begin
            state <= S_CMP_CHK;
          end
          S_CMP_CHK: begin
            if (elem_equal(row_q, row_buffer[k])) begin
              if (k_last) begin
                state <= S_HIT;
              end else begin
                k     <= k + KW'(1);
                state <= S_CMP_WAIT;
              end
            end else begin
              k <= '0;
              if (e_more) begin
                e     <= e + EW'(1);
                state <= S_CMP_WAIT;
              end else begin
                state <= is_full ? S_FULL : S_STORE;
              end
            end
          end
          S_HIT: begin
            if (out_free) begin
              res   <= '{ST_MATCH, INDEX_W'(e), cnt_inc, 1'b1};
              state <= S_IDLE;
            end
          end
          S_STORE: begin
            if (!k_last) begin
              k <= k + KW'(1);
            end else if (out_free) begin
              res          <= '{ST_NEW, INDEX_W'(new_idx), COUNT_W'(1), 1'b1};
              entries_used <= entries_used + UW'(1);
              state        <= S_IDLE;
            end
          end
          S_FULL: begin
            if (out_free) begin
              res   <= '{ST_FULL, '0, '0, 1'b1};
              state <= S_IDLE;
            end
          end
          S_EMPTY: begin
            if (out_free) begin
              res   <= '{ST_EMPTY, '0, '0, 1'b1};
              pos   <= '0;
              state <= S_IDLE;
            end
          end
          S_RD_WAIT: begin
            state <= S_RD_DATA;
          end
          S_RD_DATA: begin
            if (out_free) begin
              res <= '{ST_READOUT, INDEX_W'(e), cnt_q, rd_last};
              if (rd_last) begin
                entries_used <= '0;
                pos          <= '0;
                state        <= S_IDLE;
              end else begin
                e     <= e + EW'(1);
                state <= S_RD_WAIT;
              end
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign result.valid  = res_valid;
  assign result.status = res.status;
  assign result.index  = res.index;
  assign result.count  = res.count;
  assign result.last   = res.last;

  // Table never holds more entries than it has room for
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= UW'(MAX_DISTINCT))
    else $error("entry count above table size");

  // Partial row position stays inside the row
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (WW'(pos) < w_eff) || (state != S_IDLE))
    else $error("element position outside row");

  // A finish transaction always leaves the block busy next cycle
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    elem_take && elem.command == CMD_FINISH |=> !elem.ready)
    else $error("finish did not start readout");

  // A new entry always reports a count of one and grows the table
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    state == S_STORE && k_last && out_free |=>
      res_valid && res.count == COUNT_W'(1) && entries_used == $past(entries_used) + UW'(1))
    else $error("new entry result malformed");

  // Readout marks the last entry exactly when the index is one below the fill count
  a_readout_last: assert property (@(posedge clk) disable iff (rst)
    state == S_RD_DATA && out_free |=>
      res.last == ((UW'($past(e)) + UW'(1)) == $past(entries_used)))
    else $error("readout last flag wrong");

endmodule

>>> sim/unique_row_table_with_counts_core_tb.sv
// Testbench for the unique row table: directed table, random phases, scoreboard check.
module unique_row_table_with_counts_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import urt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned ROW_MAX      = 8;
  localparam int          LIMIT_CYCLES = 1_500_000;
  localparam int          HOLD_CYCLES  = 500;
  localparam int          SETTLE_GAP   = 16;
  localparam int          DRAIN_GAP    = 64;

  typedef enum logic [1:0] {
    DIR_ELEM,
    DIR_FINISH,
    DIR_CFG
  } dir_kind_t;

  typedef struct packed {
    dir_kind_t           kind;
    logic [VALUE_W-1:0]  val;
    logic                typed;
    status_t             st;
    logic [INDEX_W-1:0]  idx;
    logic [COUNT_W-1:0]  cnt;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_write;
  logic [RW_W-1:0] cfg_data;

  urt_elem_if   elem_ch ();
  urt_result_if res_ch ();

  unique_row_table_with_counts_core #(
    .MAX_DISTINCT (TABLE_DEPTH),
    .MAX_ROW_WIDTH(ROW_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .elem     (elem_ch),
    .result   (res_ch)
  );

  always #1 clk = ~clk;

  // Predicted table state
  logic [RW_W-1:0]    width_reg;
  logic [VALUE_W-1:0] tbl_rows   [TABLE_DEPTH][ROW_MAX];
  logic [COUNT_W-1:0] tbl_counts [TABLE_DEPTH];
  int unsigned        tbl_used;
  logic [VALUE_W-1:0] gather_buf [ROW_MAX];
  int unsigned        gather_pos;

  result_t step_out [$];
  result_t awaited  [$];

  int  error_count   = 0;
  int  items_sent    = 0;
  int  cycle_count   = 0;
  bit  no_idle       = 1'b0;
  bit  hold_request  = 1'b0;

  logic [VALUE_W-1:0] row_pool [6][ROW_MAX];

  // Directed rows: typed expectations where the outcome is obvious
  dir_row_t directed_rows [25] = '{
    '{DIR_FINISH, 64'h0,                   1'b1, ST_EMPTY,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h0000_0000_0000_0000, 1'b1, ST_NEW,     6'd0, 32'd1},
    '{DIR_ELEM,   64'h8000_0000_0000_0000, 1'b1, ST_MATCH,   6'd0, 32'd2},
    '{DIR_ELEM,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NEW,     6'd1, 32'd1},
    '{DIR_ELEM,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NEW,     6'd2, 32'd1},
    '{DIR_ELEM,   64'h7FF0_0000_0000_0000, 1'b1, ST_NEW,     6'd3, 32'd1},
    '{DIR_ELEM,   64'h7FF0_0000_0000_0000, 1'b1, ST_MATCH,   6'd3, 32'd2},
    '{DIR_ELEM,   64'hFFF0_0000_0000_0000, 1'b1, ST_NEW,     6'd4, 32'd1},
    '{DIR_ELEM,   64'h7FF0_0000_0000_0001, 1'b1, ST_NEW,     6'd5, 32'd1},
    '{DIR_ELEM,   64'h7FFF_FFFF_FFFF_FFFF, 1'b1, ST_NEW,     6'd6, 32'd1},
    '{DIR_ELEM,   64'h0000_0000_0000_0001, 1'b1, ST_NEW,     6'd7, 32'd1},
    '{DIR_ELEM,   64'h0000_0000_0000_0001, 1'b1, ST_MATCH,   6'd7, 32'd2},
    '{DIR_FINISH, 64'h0,                   1'b0, ST_READOUT, 6'd0, 32'd0},
    '{DIR_CFG,    64'd3,                   1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h3FF0_0000_0000_0000, 1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h4000_0000_0000_0000, 1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_FINISH, 64'h0,                   1'b1, ST_EMPTY,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h3FF0_0000_0000_0000, 1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h4000_0000_0000_0000, 1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h0000_0000_0000_0000, 1'b1, ST_NEW,     6'd0, 32'd1},
    '{DIR_ELEM,   64'h3FF0_0000_0000_0000, 1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h4000_0000_0000_0000, 1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h8000_0000_0000_0000, 1'b1, ST_MATCH,   6'd0, 32'd2},
    '{DIR_CFG,    64'd0,                   1'b0, ST_MATCH,   6'd0, 32'd0},
    '{DIR_ELEM,   64'h0000_0000_0000_0005, 1'b1, ST_NEW,     6'd0, 32'd1}
  };

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > RW_W'(ROW_MAX)) return ROW_MAX;
    return int'(width_reg);
  endfunction

  // IEEE equality: NaN never equal, signed zeros equal
  function automatic bit double_eq(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
    bit a_nan;
    bit b_nan;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    if (a_nan || b_nan) return 1'b0;
    if (a[62:0] == '0 && b[62:0] == '0) return 1'b1;
    return a == b;
  endfunction

  function automatic void table_clear();
    for (int e = 0; e < TABLE_DEPTH; e++) tbl_counts[e] = '0;
    tbl_used   = 0;
    gather_pos = 0;
  endfunction

  function automatic void table_config(input logic [RW_W-1:0] w);
    width_reg = w;
    table_clear();
  endfunction

  // Advance the predicted table by one transaction, results into step_out
  function automatic void table_step(input command_t cmd, input logic [VALUE_W-1:0] val);
    int unsigned w;
    int          hit_at;
    bit          hit;
    result_t     r;
    w = active_width();
    step_out.delete();
    if (cmd == CMD_FINISH) begin
      if (tbl_used == 0) begin
        r.status = ST_EMPTY;
        r.index  = '0;
        r.count  = '0;
        r.last   = 1'b1;
        step_out.push_back(r);
      end else begin
        for (int unsigned e = 0; e < tbl_used; e++) begin
          r.status = ST_READOUT;
          r.index  = INDEX_W'(e);
          r.count  = tbl_counts[e];
          r.last   = (e + 1 == tbl_used);
          step_out.push_back(r);
        end
      end
      table_clear();
      return;
    end
    if (gather_pos >= w) gather_pos = 0;
    gather_buf[gather_pos] = val;
    gather_pos++;
    if (gather_pos < w) return;
    gather_pos = 0;
    hit_at = -1;
    for (int unsigned e = 0; e < tbl_used && hit_at < 0; e++) begin
      hit = 1'b1;
      for (int unsigned k = 0; k < w; k++)
        if (!double_eq(gather_buf[k], tbl_rows[e][k])) hit = 1'b0;
      if (hit) hit_at = int'(e);
    end
    if (hit_at >= 0) begin
      if (tbl_counts[hit_at] != COUNT_MAX) tbl_counts[hit_at] = tbl_counts[hit_at] + 1'b1;
      r.status = ST_MATCH;
      r.index  = INDEX_W'(hit_at);
      r.count  = tbl_counts[hit_at];
    end else if (tbl_used >= TABLE_DEPTH) begin
      r.status = ST_FULL;
      r.index  = '0;
      r.count  = '0;
    end else begin
      for (int unsigned k = 0; k < w; k++) tbl_rows[tbl_used][k] = gather_buf[k];
      tbl_counts[tbl_used] = 1;
      r.status = ST_NEW;
      r.index  = INDEX_W'(tbl_used);
      r.count  = 1;
      tbl_used++;
    end
    r.last = 1'b1;
    step_out.push_back(r);
  endfunction

  // Element values weighted toward zeros, NaNs and infinities
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 64'h0000_0000_0000_0000;
      1:       return 64'h8000_0000_0000_0000;
      2:       return {1'($urandom), 11'h7FF, 20'($urandom), 32'($urandom) | 32'd1};
      3:       return {1'($urandom), 11'h7FF, 52'd0};
      4:       return 64'($urandom_range(0, 3));
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Offer one transaction, wait for the handshake, then predict at the falling edge
  task automatic send_item(input command_t cmd, input logic [VALUE_W-1:0] val,
                           input bit predicted);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      elem_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    elem_ch.valid   <= 1'b1;
    elem_ch.command <= cmd;
    elem_ch.value   <= val;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    table_step(cmd, val);
    if (predicted) foreach (step_out[i]) awaited.push_back(step_out[i]);
  endtask

  // Drain, let the block settle, then write the row width
  task automatic write_width(input logic [RW_W-1:0] w);
    elem_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= w;
    @(negedge clk);
    cfg_write <= 1'b0;
    table_config(w);
  endtask

  // Fill all entries with distinct rows, overflow, repeat a hit, read out
  task automatic run_fill_phase();
    int                 extra;
    logic [VALUE_W-1:0] first_v;
    extra   = $urandom_range(2, 6);
    first_v = {32'($urandom), 32'd0};
    for (int i = 0; i < TABLE_DEPTH + extra; i++)
      send_item(CMD_ELEMENT, (i == 0) ? first_v : {32'($urandom), 32'(i)}, 1'b1);
    send_item(CMD_ELEMENT, first_v, 1'b1);
    send_item(CMD_ELEMENT, first_v, 1'b1);
    send_item(CMD_FINISH, {32'($urandom), 32'($urandom)}, 1'b1);
  endtask

  // Mostly repeated rows from a small pool, with fresh rows, cut rows and finishes
  task automatic run_mix_phase(input int budget);
    int unsigned        w;
    int unsigned        npool;
    int unsigned        p;
    int unsigned        choice;
    int unsigned        cut;
    int                 start;
    logic [VALUE_W-1:0] v;
    w     = active_width();
    npool = $urandom_range(1, 6);
    start = items_sent;
    for (int i = 0; i < npool; i++)
      for (int k = 0; k < w; k++) row_pool[i][k] = pick_value();
    while (items_sent - start < budget) begin
      choice = $urandom_range(0, 19);
      if (choice < 14) begin
        p = $urandom_range(0, npool - 1);
        for (int k = 0; k < w; k++) begin
          v = row_pool[p][k];
          if (v[62:0] == '0 && $urandom_range(0, 1) == 1) v[63] = ~v[63];
          send_item(CMD_ELEMENT, v, 1'b1);
        end
      end else if (choice < 17) begin
        for (int k = 0; k < w; k++) send_item(CMD_ELEMENT, pick_value(), 1'b1);
      end else if (choice < 19) begin
        cut = $urandom_range(0, w - 1);
        for (int k = 0; k < cut; k++) send_item(CMD_ELEMENT, pick_value(), 1'b1);
        send_item(CMD_FINISH, {32'($urandom), 32'($urandom)}, 1'b1);
      end else begin
        send_item(CMD_FINISH, {32'($urandom), 32'($urandom)}, 1'b1);
      end
    end
    send_item(CMD_FINISH, {32'($urandom), 32'($urandom)}, 1'b1);
  endtask

  // Receiver: random stall bursts, plus a long hold on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest awaited one
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing awaited", 64'(res_ch.index), 64'd0);
      end else begin
        want = awaited.pop_front();
        if (res_ch.status !== want.status)
          report_mismatch("status", 64'(res_ch.status), 64'(want.status));
        if (res_ch.index !== want.index)
          report_mismatch("index", 64'(res_ch.index), 64'(want.index));
        if (res_ch.count !== want.count)
          report_mismatch("count", 64'(res_ch.count), 64'(want.count));
        if (res_ch.last !== want.last)
          report_mismatch("last", 64'(res_ch.last), 64'(want.last));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** unique_row_table_with_counts_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int       phase;
    dir_row_t d;
    result_t  r;
    logic [RW_W-1:0] w;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_data        = '0;
    elem_ch.valid   = 1'b0;
    elem_ch.command = CMD_ELEMENT;
    elem_ch.value   = '0;
    table_config(4'd1);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (directed_rows[i]) begin
      d = directed_rows[i];
      case (d.kind)
        DIR_CFG:    write_width(d.val[RW_W-1:0]);
        DIR_FINISH: send_item(CMD_FINISH, d.val, !d.typed);
        default:    send_item(CMD_ELEMENT, d.val, !d.typed);
      endcase
      if (d.typed) begin
        r.status = d.st;
        r.index  = d.idx;
        r.count  = d.cnt;
        r.last   = 1'b1;
        awaited.push_back(r);
      end
    end

    // Random part: full table first, then mixed phases over several widths
    write_width(4'd1);
    run_fill_phase();
    phase = 0;
    while (items_sent < 300) begin
      case (phase)
        0:       w = 4'd8;
        1:       w = 4'd15;
        2:       w = 4'd0;
        3:       w = 4'd1;
        default: w = RW_W'($urandom_range(0, 15));
      endcase
      write_width(w);
      if (phase == 1 || phase == 5) hold_request = 1'b1;
      run_mix_phase($urandom_range(20, 40));
      phase++;
    end

    // Closing phase with no idling on either side
    no_idle = 1'b1;
    write_width(RW_W'($urandom_range(1, 8)));
    run_mix_phase(30);

    elem_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
    if (error_count == 0) begin
      $display("** unique_row_table_with_counts_core: PASSED **");
    end else begin
      $display("** unique_row_table_with_counts_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> unique_row_table_with_counts_core.f
hdl/urt_pkg.sv
hdl/urt_elem_if.sv
hdl/urt_result_if.sv
hdl/unique_row_table_with_counts_core.sv
sim/unique_row_table_with_counts_core_tb.sv
